// ===== rtl/nes_pkg.sv =====
`default_nettype none

package nes_pkg;

	// Default sizes of the arrival store and of the internal time word.
	localparam int DEF_QUEUE_DEPTH = 64;
	localparam int DEF_TIME_BITS   = 32;

	// The time fields on the ports are 32 bits wide, whatever the internal width.
	localparam int FIELD_TIME_BITS = 32;
	localparam int MAX_TIME_BITS   = 64;
	localparam int PROC_BITS       = 8;

	// Tick period register.
	localparam int              PERIOD_BITS = 16;
	localparam logic [15:0]     TICK_RESET  = 16'd10;

	// Input tdata layout, from the lowest bit up.
	localparam int PROC_LSB     = 0;
	localparam int TV_LSB       = 8;
	localparam int BL_LSB       = 40;
	localparam int BD_LSB       = 72;
	localparam int IN_DATA_BITS = 104;

	// Output tdata layout, from the lowest bit up.
	localparam int OUT_DATA_BITS = 80;
	localparam int OUT_PAD_BITS  = 6;

	typedef enum logic [1:0] {
		ACT_ADD    = 2'd0,
		ACT_FINISH = 2'd1,
		ACT_POP    = 2'd2,
		ACT_NOP    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		EV_TICK    = 2'd0,
		EV_FINISH  = 2'd1,
		EV_ARRIVAL = 2'd2,
		EV_NONE    = 2'd3
	} event_kind_t;

	// Shift commands broadcast to every cell of the arrival chain.
	typedef struct packed {
		logic insert;
		logic pop;
	} nes_cell_ctrl_t;

endpackage

`default_nettype wire

// ===== rtl/next_event_selector_top.sv =====
// Event selector for a scheduler.
// Input channel s_*: one transaction per request. s_tuser carries the action
// (add arrival, set finish time, pop next event); s_tdata carries the process
// id, time value, burst length and elapsed burst. Output channel m_*: exactly
// one result transaction per request, event kind in m_tuser.
// Arrivals live in a sorted chain of cells, earliest at the head; an add
// shifts the later entries right unless the store is full, and a pop that
// takes an arrival shifts the chain left. Add, set finish and idle actions:
// the result passes the result register and then the output register, and
// the next request can be taken in the cycle that the result appears.
// Pop: the result waits until a bit-serial remainder unit has rebuilt the
// next timer tick. A write to the tick period register starts the same
// recalculation; s_tready stays low until that recalculation is done.
// At reset the store is empty, the finish time is idle (all ones), the last
// event time is zero and the next tick is 10.
// The output register holds a result until m_tready; the block goes on to the
// next request meanwhile and stalls only when a second result is ready.
`default_nettype none

module next_event_selector_top
	import nes_pkg::*;
#(
	parameter int QUEUE_DEPTH = DEF_QUEUE_DEPTH,
	parameter int TIME_BITS   = DEF_TIME_BITS
) (
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     cfg_wr_en,
	input  wire logic [PERIOD_BITS-1:0]   cfg_wr_data,   // tick_period
	input  wire logic                     s_tvalid,
	output logic                          s_tready,
	// proc_id[7:0], time_value[39:8], burst_length[71:40], burst_done[103:72]
	input  wire logic [IN_DATA_BITS-1:0]  s_tdata,
	// action[1:0]
	input  wire logic [1:0]               s_tuser,
	output logic                          m_tvalid,
	input  wire logic                     m_tready,
	// event_time[31:0], event_proc[39:32], upcoming_time[71:40],
	// all_quiet[72], store_full[73], zero padding above
	output logic [OUT_DATA_BITS-1:0]      m_tdata,
	// event_kind[1:0]
	output logic [1:0]                    m_tuser
);

	localparam logic [TIME_BITS-1:0] IDLE = '1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_START,
		S_WAIT,
		S_OUT
	} state_t;

	state_t                 state_q;
	logic                   recalc_q;
	logic                   emit_q;
	logic [PERIOD_BITS-1:0] tick_period_q;
	logic [TIME_BITS-1:0]   finish_q;
	logic [TIME_BITS-1:0]   last_q;
	event_kind_t            res_kind_q;
	logic [TIME_BITS-1:0]   res_time_q;
	logic [PROC_BITS-1:0]   res_proc_q;
	logic                   res_full_q;

	logic                       out_valid_q;
	event_kind_t                out_kind_q;
	logic [FIELD_TIME_BITS-1:0] out_time_q;
	logic [PROC_BITS-1:0]       out_proc_q;
	logic [FIELD_TIME_BITS-1:0] out_up_q;
	logic                       out_quiet_q;
	logic                       out_full_q;

	// Input fields resized to the internal time width.
	logic [MAX_TIME_BITS-1:0] tv_wide, bl_wide, bd_wide;
	logic [TIME_BITS-1:0]     in_tv, in_bl, in_bd;
	logic [PROC_BITS-1:0]     in_pid;
	action_t                  in_act;

	assign tv_wide = MAX_TIME_BITS'(s_tdata[TV_LSB +: FIELD_TIME_BITS]);
	assign bl_wide = MAX_TIME_BITS'(s_tdata[BL_LSB +: FIELD_TIME_BITS]);
	assign bd_wide = MAX_TIME_BITS'(s_tdata[BD_LSB +: FIELD_TIME_BITS]);
	assign in_tv   = tv_wide[TIME_BITS-1:0];
	assign in_bl   = bl_wide[TIME_BITS-1:0];
	assign in_bd   = bd_wide[TIME_BITS-1:0];
	assign in_pid  = s_tdata[PROC_LSB +: PROC_BITS];
	assign in_act  = action_t'(s_tuser);

	logic accept;
	assign s_tready = (state_q == S_IDLE) && !recalc_q;
	assign accept   = s_tvalid && s_tready;

	// Arrival chain.
	logic                 c_valid [QUEUE_DEPTH];
	logic [TIME_BITS-1:0] c_time  [QUEUE_DEPTH];
	logic [PROC_BITS-1:0] c_id    [QUEUE_DEPTH];
	logic                 c_keep  [QUEUE_DEPTH];

	nes_cell_ctrl_t cell_ctrl;
	logic           store_is_full;

	assign store_is_full = c_valid[QUEUE_DEPTH-1];

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_cell
			logic                 l_keep, l_valid, r_valid;
			logic [TIME_BITS-1:0] l_time, r_time;
			logic [PROC_BITS-1:0] l_id, r_id;

			if (gi == 0) begin : g_head
				assign l_keep  = 1'b1;
				assign l_valid = 1'b1;
				assign l_time  = in_tv;
				assign l_id    = in_pid;
			end else begin : g_body
				assign l_keep  = c_keep[gi-1];
				assign l_valid = c_valid[gi-1];
				assign l_time  = c_time[gi-1];
				assign l_id    = c_id[gi-1];
			end

			if (gi == QUEUE_DEPTH - 1) begin : g_tail
				assign r_valid = 1'b0;
				assign r_time  = '0;
				assign r_id    = '0;
			end else begin : g_inner
				assign r_valid = c_valid[gi+1];
				assign r_time  = c_time[gi+1];
				assign r_id    = c_id[gi+1];
			end

			nes_cell #(
				.TIME_BITS(TIME_BITS)
			) u_cell (
				.clk        (clk),
				.arst_n     (arst_n),
				.ctrl       (cell_ctrl),
				.new_time   (in_tv),
				.new_id     (in_pid),
				.left_keep  (l_keep),
				.left_valid (l_valid),
				.left_time  (l_time),
				.left_id    (l_id),
				.right_valid(r_valid),
				.right_time (r_time),
				.right_id   (r_id),
				.valid      (c_valid[gi]),
				.cell_time  (c_time[gi]),
				.cell_id    (c_id[gi]),
				.keep       (c_keep[gi])
			);
		end
	endgenerate

	// Next timer tick unit.
	logic                 div_start;
	logic                 div_done;
	logic [TIME_BITS-1:0] next_tick;

	assign div_start = (state_q == S_START);

	nes_tick_div #(
		.TIME_BITS(TIME_BITS)
	) u_tick_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.last_time(last_q),
		.period   (tick_period_q),
		.done     (div_done),
		.next_tick(next_tick)
	);

	// Earliest of tick, finish and head arrival; ties favor arrival, then finish.
	// At acceptance this is the pop choice, in S_OUT it is the upcoming time.
	event_kind_t          sel_kind;
	logic [TIME_BITS-1:0] sel_time;

	always_comb begin
		sel_kind = EV_TICK;
		sel_time = next_tick;
		if (finish_q <= sel_time) begin
			sel_kind = EV_FINISH;
			sel_time = finish_q;
		end
		if (c_valid[0] && (c_time[0] <= sel_time)) begin
			sel_kind = EV_ARRIVAL;
			sel_time = c_time[0];
		end
	end

	// Chain commands for the accepted transaction.
	always_comb begin
		cell_ctrl.insert = accept && (in_act == ACT_ADD) && !store_is_full;
		cell_ctrl.pop    = accept && (in_act == ACT_POP) && (sel_kind == EV_ARRIVAL);
	end

	// Output fields narrowed to the port width.
	logic [MAX_TIME_BITS-1:0] res_time_wide, up_time_wide;
	logic                     out_load;

	assign res_time_wide = MAX_TIME_BITS'(res_time_q);
	assign up_time_wide  = MAX_TIME_BITS'(sel_time);
	assign out_load      = (state_q == S_OUT) && (!out_valid_q || m_tready);

	// Sequencer, architectural state and the output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_IDLE;
			recalc_q      <= 1'b0;
			emit_q        <= 1'b0;
			tick_period_q <= TICK_RESET;
			finish_q      <= IDLE;
			last_q        <= '0;
			res_kind_q    <= EV_NONE;
			res_time_q    <= '0;
			res_proc_q    <= '0;
			res_full_q    <= 1'b0;
			out_valid_q   <= 1'b0;
			out_kind_q    <= EV_NONE;
			out_time_q    <= '0;
			out_proc_q    <= '0;
			out_up_q      <= '0;
			out_quiet_q   <= 1'b0;
			out_full_q    <= 1'b0;
		end else begin
			// A period write asks for a new tick; the request clears once started.
			if (cfg_wr_en) begin
				tick_period_q <= cfg_wr_data;
				recalc_q      <= 1'b1;
			end else if ((state_q == S_IDLE) && recalc_q) begin
				recalc_q <= 1'b0;
			end

			// The output register fills from S_OUT and empties on the handshake.
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tvalid && m_tready) begin
				out_valid_q <= 1'b0;
			end

			unique case (state_q)
				S_IDLE: begin
					if (recalc_q) begin
						emit_q  <= 1'b0;
						state_q <= S_START;
					end else if (accept) begin
						res_kind_q <= (in_act == ACT_POP) ? sel_kind : EV_NONE;
						res_time_q <= (in_act == ACT_POP) ? sel_time : '0;
						res_proc_q <= ((in_act == ACT_POP) && (sel_kind == EV_ARRIVAL))
						              ? c_id[0] : '0;
						res_full_q <= (in_act == ACT_ADD) && store_is_full;
						emit_q     <= (in_act == ACT_POP);
						state_q    <= (in_act == ACT_POP) ? S_START : S_OUT;
						if (in_act == ACT_FINISH) begin
							finish_q <= in_tv + in_bl - in_bd;
						end
						if (in_act == ACT_POP) begin
							last_q <= sel_time;
						end
					end
				end
				S_START: begin
					state_q <= S_WAIT;
				end
				S_WAIT: begin
					if (div_done) begin
						state_q <= emit_q ? S_OUT : S_IDLE;
					end
				end
				S_OUT: begin
					if (out_load) begin
						out_kind_q  <= res_kind_q;
						out_time_q  <= res_time_wide[FIELD_TIME_BITS-1:0];
						out_proc_q  <= res_proc_q;
						out_up_q    <= up_time_wide[FIELD_TIME_BITS-1:0];
						out_quiet_q <= !c_valid[0] && (finish_q == IDLE);
						out_full_q  <= res_full_q;
						state_q     <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_kind_q;
	assign m_tdata  = {{OUT_PAD_BITS{1'b0}}, out_full_q, out_quiet_q, out_up_q,
	                   out_proc_q, out_time_q};

endmodule

`default_nettype wire

// ===== rtl/nes_cell.sv =====
`default_nettype none

module nes_cell
	import nes_pkg::*;
#(
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire nes_cell_ctrl_t       ctrl,
	input  wire logic [TIME_BITS-1:0] new_time,
	input  wire logic [PROC_BITS-1:0] new_id,
	input  wire logic                 left_keep,
	input  wire logic                 left_valid,
	input  wire logic [TIME_BITS-1:0] left_time,
	input  wire logic [PROC_BITS-1:0] left_id,
	input  wire logic                 right_valid,
	input  wire logic [TIME_BITS-1:0] right_time,
	input  wire logic [PROC_BITS-1:0] right_id,
	output logic                      valid,
	output logic [TIME_BITS-1:0]      cell_time,
	output logic [PROC_BITS-1:0]      cell_id,
	output logic                      keep
);

	logic                 valid_q;
	logic [TIME_BITS-1:0] time_q;
	logic [PROC_BITS-1:0] id_q;

	// An entry at or before the new time stays put, so equal times keep arrival order.
	assign keep = valid_q && (time_q <= new_time);

	// Valid bit: insert takes the new item or the left neighbor, pop takes the right one.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.insert) begin
			if (!keep) begin
				valid_q <= left_keep ? 1'b1 : left_valid;
			end
		end else if (ctrl.pop) begin
			valid_q <= right_valid;
		end
	end

	// Payload moves the same way as the valid bit.
	always_ff @(posedge clk) begin
		if (ctrl.insert) begin
			if (!keep) begin
				time_q <= left_keep ? new_time : left_time;
				id_q   <= left_keep ? new_id : left_id;
			end
		end else if (ctrl.pop) begin
			time_q <= right_time;
			id_q   <= right_id;
		end
	end

	assign valid     = valid_q;
	assign cell_time = time_q;
	assign cell_id   = id_q;

endmodule

`default_nettype wire

// ===== rtl/nes_tick_div.sv =====
`default_nettype none

module nes_tick_div
	import nes_pkg::*;
#(
	parameter int TIME_BITS = DEF_TIME_BITS
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   start,
	input  wire logic [TIME_BITS-1:0]   last_time,
	input  wire logic [PERIOD_BITS-1:0] period,
	output logic                        done,
	output logic [TIME_BITS-1:0]        next_tick
);

	localparam int CNT_W = $clog2(TIME_BITS + 1);

	logic                   busy_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [TIME_BITS-1:0]   base_q;
	logic [TIME_BITS-1:0]   shift_q;
	logic [PERIOD_BITS-1:0] div_q;
	logic [PERIOD_BITS-1:0] rem_q;
	logic [TIME_BITS-1:0]   next_q;

	logic [PERIOD_BITS:0]   trial;
	logic [PERIOD_BITS:0]   diff;
	logic [PERIOD_BITS-1:0] rem_next;

	// One restoring remainder step per cycle, most significant dividend bit first.
	always_comb begin
		trial    = {rem_q, shift_q[TIME_BITS-1]};
		diff     = trial - {1'b0, div_q};
		rem_next = (trial >= {1'b0, div_q}) ? diff[PERIOD_BITS-1:0]
		                                    : trial[PERIOD_BITS-1:0];
	end

	assign done = busy_q && (cnt_q == '0);

	// A zero period counts as one; the next tick is last - (last mod p) + p.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			cnt_q   <= '0;
			base_q  <= '0;
			shift_q <= '0;
			div_q   <= '0;
			rem_q   <= '0;
			next_q  <= TIME_BITS'(TICK_RESET);
		end else if (start) begin
			busy_q  <= 1'b1;
			cnt_q   <= CNT_W'(TIME_BITS);
			base_q  <= last_time;
			shift_q <= last_time;
			div_q   <= (period == '0) ? PERIOD_BITS'(1) : period;
			rem_q   <= '0;
		end else if (busy_q) begin
			if (cnt_q != '0) begin
				rem_q   <= rem_next;
				shift_q <= shift_q << 1;
				cnt_q   <= cnt_q - CNT_W'(1);
			end else begin
				next_q <= base_q - TIME_BITS'(rem_q) + TIME_BITS'(div_q);
				busy_q <= 1'b0;
			end
		end
	end

	assign next_tick = next_q;

endmodule

`default_nettype wire
